// File: sv/bivariate_empirical_cdf_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bivariate empirical CDF block
// Shared concurrent check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BIVARIATE_EMPIRICAL_CDF_MACROS_SVH
`define BIVARIATE_EMPIRICAL_CDF_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BECDF_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BECDF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/becdf_pkg.sv
// ----------------------------------------------------------------------------
// Bivariate empirical CDF package
// Default sizes, fraction width and the control group sent to the cell row.
// ----------------------------------------------------------------------------
package becdf_pkg;

    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int FRAC_W          = 16;
    localparam int ITER_W          = $clog2(FRAC_W);

    typedef struct packed {
        logic init;
        logic step;
        logic pop;
    } becdf_ctrl_t;

endpackage

// File: sv/becdf_cell.sv
// ----------------------------------------------------------------------------
// Dominance cell
// Holds one stored point, compares it with the point passing through the ring
// and counts the passing points it dominates; the counts later shift toward cell zero.
// ----------------------------------------------------------------------------
module becdf_cell
    import becdf_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  becdf_ctrl_t            ctrl,
    input  logic                   wr_en,
    input  logic [COORD_WIDTH-1:0] wr_x,
    input  logic [COORD_WIDTH-1:0] wr_y,
    input  logic [CNT_W-1:0]       point_count,
    input  logic [COORD_WIDTH-1:0] pass_x_in,
    input  logic [COORD_WIDTH-1:0] pass_y_in,
    input  logic                   pass_v_in,
    output logic [COORD_WIDTH-1:0] pass_x_out,
    output logic [COORD_WIDTH-1:0] pass_y_out,
    output logic                   pass_v_out,
    input  logic [CNT_W-1:0]       cnt_in,
    output logic [CNT_W-1:0]       cnt_out
);

    logic [COORD_WIDTH-1:0] own_x_reg;
    logic [COORD_WIDTH-1:0] own_y_reg;
    logic [COORD_WIDTH-1:0] pass_x_reg;
    logic [COORD_WIDTH-1:0] pass_y_reg;
    logic                   pass_v_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   own_valid;
    logic                   hit;

    assign own_valid = point_count > CNT_W'(IDX);
    assign hit = pass_v_reg
              && ($signed(pass_x_reg) <= $signed(own_x_reg))
              && ($signed(pass_y_reg) <= $signed(own_y_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en && (point_count == CNT_W'(IDX)))
        begin
            own_x_reg <= wr_x;
            own_y_reg <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            pass_x_reg <= own_x_reg;
            pass_y_reg <= own_y_reg;
            cnt_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            pass_x_reg <= pass_x_in;
            pass_y_reg <= pass_y_in;
            if (hit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        else if (ctrl.pop)
        begin
            cnt_reg <= cnt_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_v_reg <= 1'b0;
        end
        else if (ctrl.init)
        begin
            pass_v_reg <= own_valid;
        end
        else if (ctrl.step)
        begin
            pass_v_reg <= pass_v_in;
        end
    end

    assign pass_x_out = pass_x_reg;
    assign pass_y_out = pass_y_reg;
    assign pass_v_out = pass_v_reg;
    assign cnt_out    = cnt_reg;

endmodule

// File: sv/becdf_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(count * 2^16 / divisor), one quotient bit
// per cycle, for a count below the divisor.
// ----------------------------------------------------------------------------
`include "bivariate_empirical_cdf_macros.svh"

module becdf_div
    import becdf_pkg::*;
#(
    parameter int CNT_W = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  dividend,
    input  logic [CNT_W:0]    divisor,
    output logic              done,
    output logic [FRAC_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    div_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [CNT_W+1:0]  rem_shift;
    logic [CNT_W+1:0]  diff;
    logic              fits;
    logic [CNT_W:0]    rem_next;

    assign rem_shift = {rem_reg, 1'b0};
    assign diff      = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign rem_next  = fits ? diff[CNT_W:0] : rem_shift[CNT_W:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `BECDF_CHECK(a_div_idle_start, start, !busy_reg, "Divider started while busy.")
    `BECDF_CHECK_NEXT(a_div_busy, start, busy_reg && !done_reg, "Divider did not begin.")

endmodule

// File: sv/bivariate_empirical_cdf.sv
// ----------------------------------------------------------------------------
// Bivariate empirical CDF
// Loads a point set into a ring of cells, counts for each point the points
// no greater in both coordinates, and emits count and count / (n + 1).
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  in      | in_valid, in_stall  | x_coord, y_coord, last_point
//  out     | out_valid, out_stall| point_index, dominated_count, ecdf_fraction,
//          |                     | overflow_flag, last_result
//
// Points load at one per cycle while the block is in its load phase.
// After the last point, the ring is primed and then rotated until every
// point has passed every cell.
// Each result then passes through divider start, 16 divider steps, divider
// done and output, and out_stall may hold it there.
// in_stall is high from the last point until the final result is taken.
// Reset clears the phase, the point count and the overflow mark.
// ----------------------------------------------------------------------------
`include "bivariate_empirical_cdf_macros.svh"

module bivariate_empirical_cdf
    import becdf_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int IDX_W      = $clog2(MAX_POINTS),
    localparam int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_WIDTH-1:0] x_coord,
    input  logic [COORD_WIDTH-1:0] y_coord,
    input  logic                   last_point,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [IDX_W-1:0]       point_index,
    output logic [CNT_W-1:0]       dominated_count,
    output logic [FRAC_W-1:0]      ecdf_fraction,
    output logic                   overflow_flag,
    output logic                   last_result
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_COUNT = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_index_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [FRAC_W-1:0] out_frac_reg;
    logic              out_ovf_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              out_take;
    logic              full;
    logic              is_last_idx;
    becdf_ctrl_t       ctrl;
    logic              div_done;
    logic [FRAC_W-1:0] div_quo;

    logic [COORD_WIDTH-1:0] pass_x [MAX_POINTS];
    logic [COORD_WIDTH-1:0] pass_y [MAX_POINTS];
    logic                   pass_v [MAX_POINTS];
    logic [CNT_W-1:0]       cnt    [MAX_POINTS];

    assign in_stall    = (state_reg != S_LOAD);
    assign in_accept   = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign full        = (count_reg == CNT_W'(MAX_POINTS));
    assign is_last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign ctrl.init = (state_reg == S_COUNT) && (step_reg == '0);
    assign ctrl.step = (state_reg == S_COUNT) && (step_reg != '0);
    assign ctrl.pop  = (state_reg == S_DIV) && div_done;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            localparam int PREV = (gi == 0) ? MAX_POINTS - 1 : gi - 1;
            logic [CNT_W-1:0] cnt_from_next;

            if (gi == MAX_POINTS - 1)
            begin : g_tail
                assign cnt_from_next = '0;
            end
            else
            begin : g_body
                assign cnt_from_next = cnt[gi + 1];
            end

            becdf_cell #(
                .COORD_WIDTH (COORD_WIDTH),
                .MAX_POINTS  (MAX_POINTS),
                .IDX         (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .wr_en       (in_accept && !full),
                .wr_x        (x_coord),
                .wr_y        (y_coord),
                .point_count (count_reg),
                .pass_x_in   (pass_x[PREV]),
                .pass_y_in   (pass_y[PREV]),
                .pass_v_in   (pass_v[PREV]),
                .pass_x_out  (pass_x[gi]),
                .pass_y_out  (pass_y[gi]),
                .pass_v_out  (pass_v[gi]),
                .cnt_in      (cnt_from_next),
                .cnt_out     (cnt[gi])
            );
        end
    endgenerate

    becdf_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend (cnt[0]),
        .divisor  ({1'b0, count_reg} + (CNT_W + 1)'(1)),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_point)
                    begin
                        state_next = S_COUNT;
                        step_next  = '0;
                    end
                end
            end
            S_COUNT:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(MAX_POINTS))
                begin
                    state_next = S_START;
                    idx_next   = '0;
                end
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next     = S_OUT;
                    out_valid_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next   = S_LOAD;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_START;
                        idx_next   = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            out_index_reg <= idx_reg;
            out_count_reg <= cnt[0];
            out_frac_reg  <= div_quo;
            out_ovf_reg   <= dropped_reg;
            out_last_reg  <= is_last_idx;
        end
    end

    assign out_valid       = out_valid_reg;
    assign point_index     = out_index_reg;
    assign dominated_count = out_count_reg;
    assign ecdf_fraction   = out_frac_reg;
    assign overflow_flag   = out_ovf_reg;
    assign last_result     = out_last_reg;

    `BECDF_CHECK_NEXT(a_drop_marked, in_accept && full, dropped_reg, "Dropped point not marked.")
    `BECDF_CHECK_NEXT(a_set_closed, out_take && out_last_reg, (state_reg == S_LOAD) && (count_reg == '0), "Set not closed after final transaction.")
    `BECDF_CHECK(a_index_range, out_valid_reg, CNT_W'(out_index_reg) < count_reg, "Result index beyond point count.")

endmodule
